/* src/fnvsm_pkg.sv */
// Package with the shared constants, types and state encoding of the seed hash block.
`default_nettype none

package fnvsm_pkg;

  localparam logic [63:0] FnvOffsetBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime       = 64'h00000100000001B3;
  localparam logic [63:0] PrefixDomain   = 64'h504F4C5942454C31;
  localparam logic [63:0] PrefixVersion  = 64'h0000000000000001;
  localparam logic [63:0] MixMulA        = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB        = 64'h94D049BB133111EB;

  // Absorbs the low n bytes of w into h, low byte first. Used for constants only.
  function automatic logic [63:0] absorb_const(logic [63:0] h, logic [63:0] w,
                                               int unsigned n);
    logic [63:0] acc;
    logic [63:0] shw;
    acc = h;
    shw = w;
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc ^ {56'd0, shw[7:0]};
      acc = acc * FnvPrime;
      shw = shw >> 8;
    end
    return acc;
  endfunction

  // Hash state with the domain constant and the version word already absorbed.
  localparam logic [63:0] PrefixValue =
    absorb_const(absorb_const(FnvOffsetBasis, PrefixDomain, 8), PrefixVersion, 4);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABSORB,
    S_WAIT_ABS,
    S_MIX_A,
    S_WAIT_A,
    S_MIX_B,
    S_WAIT_B,
    S_FOLD
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

/* src/fnvsm_in_if.sv */
// Input channel: one word of a message per item.
`default_nettype none

interface fnvsm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic        wide_word;
  logic        last_word;

  modport source (output valid, output data_word, output wide_word, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input wide_word, input last_word,
                output ready);
endinterface

`default_nettype wire

/* src/fnvsm_out_if.sv */
// Output channel: one seed per item.
`default_nettype none

interface fnvsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

`default_nettype wire

/* src/fnvsm_mul.sv */
// Iterative 64 x 64 multiplier, low 64 bits, built from one 32 x 32 multiplier.
`default_nettype none

module fnvsm_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fnvsm_pkg::mul_req_t req_i,
  output      fnvsm_pkg::mul_rsp_t rsp_o
);

  logic [63:0] a_q, b_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  step_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;

  // Partial products: low x low, low x high, high x low. The high x high
  // product falls entirely above bit 63.
  always_comb begin
    case (step_q)
      2'd0:    begin op_a = a_q[31:0];  op_b = b_q[31:0];  end
      2'd1:    begin op_a = a_q[31:0];  op_b = b_q[63:32]; end
      2'd2:    begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
      default: begin op_a = a_q[63:32]; op_b = b_q[31:0];  end
    endcase
  end

  assign pp = 64'(op_a) * 64'(op_b);

  // The product of the previous step, held in prod_q, is added in the next step.
  always_comb begin
    case (step_q)
      2'd0:    acc_d = acc_q;
      2'd1:    acc_d = acc_q + prod_q;
      default: acc_d = acc_q + {prod_q[31:0], 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= 64'd0;
    end else if (busy_q) begin
      prod_q <= pp;
      acc_q  <= acc_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

/* src/fnv1a_splitmix_seed_hash_top.sv */
// Top level of the FNV-1a seed hash with splitmix64 finalizer and 32-bit fold.
//
// Usage: messages arrive as words on in_i, one word per item. A narrow word
// absorbs its low 4 bytes, a wide word all 8, low byte first. A word marked
// last produces one 32-bit seed on out_o; other words produce nothing.
// Sequence: each byte passes through the shared 32 x 32 multiplier (an issue
// state, the multiplier's own steps, then a wait state that takes the
// product). A last word then runs the two finalizer multiplies and the fold
// before the seed appears in the output register. A new word is taken only
// once the previous one is done: in_i.ready is high only while the
// sequencer is idle.
// Reset clears the sequencer and the output register and leaves the running
// hash at the prefix value, so the first message needs no setup.
// The output register holds the seed until out_o.ready takes it. The block
// keeps accepting and absorbing words meanwhile, and only stalls at the fold
// of the next message if the previous seed is still unclaimed.
`default_nettype none

module fnv1a_splitmix_seed_hash_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fnvsm_in_if.sink    in_i,
  fnvsm_out_if.source out_o
);

  fnvsm_pkg::state_e   state_q, state_d;
  logic [63:0]         hash_q, hash_d;
  logic [63:0]         word_q, word_d;
  logic [2:0]          idx_q, idx_d;
  logic                wide_q, wide_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         seed_q, seed_d;
  fnvsm_pkg::mul_req_t mul_req;
  fnvsm_pkg::mul_rsp_t mul_rsp;
  logic [63:0]         fin;
  logic [31:0]         folded;
  logic                out_free;

  fnvsm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign fin      = hash_q ^ (hash_q >> 31);
  assign folded   = fin[31:0] ^ fin[63:32];
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    word_d      = word_q;
    idx_d       = idx_q;
    wide_d      = wide_q;
    last_d      = last_q;
    seed_d      = seed_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mul_req     = '{start: 1'b0, a: hash_q, b: fnvsm_pkg::FnvPrime};

    case (state_q)
      fnvsm_pkg::S_IDLE: begin
        if (in_i.valid) begin
          word_d  = in_i.data_word;
          wide_d  = in_i.wide_word;
          last_d  = in_i.last_word;
          idx_d   = 3'd0;
          state_d = fnvsm_pkg::S_ABSORB;
        end
      end
      fnvsm_pkg::S_ABSORB: begin
        mul_req = '{start: 1'b1, a: hash_q ^ {56'd0, word_q[7:0]},
                    b: fnvsm_pkg::FnvPrime};
        state_d = fnvsm_pkg::S_WAIT_ABS;
      end
      fnvsm_pkg::S_WAIT_ABS: begin
        if (mul_rsp.done) begin
          hash_d = mul_rsp.prod;
          word_d = word_q >> 8;
          idx_d  = idx_q + 3'd1;
          if (idx_q == (wide_q ? 3'd7 : 3'd3)) begin
            state_d = last_q ? fnvsm_pkg::S_MIX_A : fnvsm_pkg::S_IDLE;
          end else begin
            state_d = fnvsm_pkg::S_ABSORB;
          end
        end
      end
      fnvsm_pkg::S_MIX_A: begin
        mul_req = '{start: 1'b1, a: hash_q ^ (hash_q >> 30), b: fnvsm_pkg::MixMulA};
        state_d = fnvsm_pkg::S_WAIT_A;
      end
      fnvsm_pkg::S_WAIT_A: begin
        if (mul_rsp.done) begin
          hash_d  = mul_rsp.prod;
          state_d = fnvsm_pkg::S_MIX_B;
        end
      end
      fnvsm_pkg::S_MIX_B: begin
        mul_req = '{start: 1'b1, a: hash_q ^ (hash_q >> 27), b: fnvsm_pkg::MixMulB};
        state_d = fnvsm_pkg::S_WAIT_B;
      end
      fnvsm_pkg::S_WAIT_B: begin
        if (mul_rsp.done) begin
          hash_d  = mul_rsp.prod;
          state_d = fnvsm_pkg::S_FOLD;
        end
      end
      fnvsm_pkg::S_FOLD: begin
        // Wait here only while the previous seed is still unclaimed.
        if (out_free) begin
          seed_d      = (folded == 32'd0) ? 32'd1 : folded;
          out_valid_d = 1'b1;
          hash_d      = fnvsm_pkg::PrefixValue;
          state_d     = fnvsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fnvsm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fnvsm_pkg::S_IDLE;
      hash_q      <= fnvsm_pkg::PrefixValue;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    idx_q  <= idx_d;
    wide_q <= wide_d;
    last_q <= last_d;
    seed_q <= seed_d;
  end

  assign in_i.ready  = (state_q == fnvsm_pkg::S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.seed  = seed_q;

  // The multiplier is never left running when a new word may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mul_rsp.busy)
    else $error("multiplier busy while idle");

  // Products only come back while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == fnvsm_pkg::S_WAIT_ABS || state_q == fnvsm_pkg::S_WAIT_A ||
                      state_q == fnvsm_pkg::S_WAIT_B))
    else $error("multiplier result outside a wait state");

  // A new seed is loaded only by the fold step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fnvsm_pkg::S_FOLD))
    else $error("seed appeared without a fold");

  // After the fold the running hash is back at the prefix value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fnvsm_pkg::S_FOLD && out_free) |=> hash_q == fnvsm_pkg::PrefixValue)
    else $error("hash not restored after message");

endmodule

`default_nettype wire

/* tb/fnv1a_splitmix_seed_hash_top_tb.sv */
// Self-checking testbench for the FNV-1a seed hash with splitmix64 finalizer.
`timescale 1ns / 100ps

module fnv1a_splitmix_seed_hash_top_tb;

  localparam logic [63:0] OffsetBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] HashPrime   = 64'h00000100000001B3;
  localparam logic [63:0] DomainWord  = 64'h504F4C5942454C31;
  localparam logic [63:0] VersionWord = 64'h0000000000000001;
  localparam logic [63:0] MixConstA   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixConstB   = 64'h94D049BB133111EB;

  localparam int NumRandomWords = 1200;
  localparam int DrainCycles    = 100;
  localparam int NumDirected    = 21;

  typedef struct packed {
    logic [63:0] data;
    logic        wide;
    logic        last;
  } msg_word_t;

  // Directed words: extremes, narrow words with the upper half set, single-word
  // messages of both widths, and multi-word messages. Seeds come from the predictor.
  msg_word_t directed_words [NumDirected] = '{
    '{64'h0000000000000000, 1'b0, 1'b1},
    '{64'h0000000000000000, 1'b1, 1'b1},
    '{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b1},
    '{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1},
    '{64'hFFFFFFFF00000000, 1'b0, 1'b1},
    '{64'h1234567800000000, 1'b0, 1'b1},
    '{64'h00000000FFFFFFFF, 1'b0, 1'b1},
    '{64'h0123456789ABCDEF, 1'b1, 1'b0},
    '{64'h00000000DEADBEEF, 1'b0, 1'b0},
    '{64'hFEDCBA9876543210, 1'b1, 1'b1},
    '{64'h0000000000000001, 1'b0, 1'b0},
    '{64'h0000000000000002, 1'b0, 1'b0},
    '{64'h0000000000000003, 1'b0, 1'b0},
    '{64'h0000000000000004, 1'b0, 1'b1},
    '{64'h8000000000000000, 1'b1, 1'b1},
    '{64'h0000000080000000, 1'b0, 1'b1},
    '{64'h0000000000000001, 1'b1, 1'b1},
    '{64'h504F4C5942454C31, 1'b1, 1'b0},
    '{64'h0000000000000001, 1'b0, 1'b1},
    '{64'h5555555555555555, 1'b1, 1'b0},
    '{64'hAAAAAAAAAAAAAAAA, 1'b1, 1'b1}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  fnvsm_in_if  in_if ();
  fnvsm_out_if out_if ();

  fnv1a_splitmix_seed_hash_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  logic [63:0] prefix_hash;
  logic [63:0] running_hash;
  logic [31:0] pending_seeds [$];
  logic        in_calm;
  logic        out_calm;
  int          err_count;
  int          words_sent;
  int          msgs_sent;
  int          seeds_checked;

  function automatic logic [63:0] absorb_word(logic [63:0] h, logic [63:0] data,
                                              logic wide);
    int nbytes;
    nbytes = wide ? 8 : 4;
    for (int i = 0; i < nbytes; i++) begin
      h = (h ^ {56'd0, data[8*i +: 8]}) * HashPrime;
    end
    return h;
  endfunction

  function automatic logic [31:0] fold_seed(logic [63:0] h);
    logic [63:0] v;
    logic [31:0] f;
    v = h ^ (h >> 30);
    v = v * MixConstA;
    v = v ^ (v >> 27);
    v = v * MixConstB;
    v = v ^ (v >> 31);
    f = v[31:0] ^ v[63:32];
    return (f == 32'd0) ? 32'd1 : f;
  endfunction

  // Long stretches without gaps are entered and left at random.
  function automatic int draw_gap(logic calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_word(input msg_word_t w);
    int gap;
    if ($urandom_range(0, 59) == 0) in_calm = ~in_calm;
    gap = draw_gap(in_calm);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_word <= w.data;
    in_if.wide_word <= w.wide;
    in_if.last_word <= w.last;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    running_hash = absorb_word(running_hash, w.data, w.wide);
    if (w.last) begin
      pending_seeds.insert(pending_seeds.size(), fold_seed(running_hash));
      running_hash = prefix_hash;
      msgs_sent++;
    end
  endtask

  function automatic logic [63:0] random_data();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom(), 32'd0};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Result side: random back-pressure, each seed compared with the oldest prediction.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    out_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
      gap = draw_gap(out_calm);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (pending_seeds.size() == 0) begin
        $error("seed: unexpected result %h with no prediction pending", out_if.seed);
        err_count++;
      end else begin
        if (out_if.seed !== pending_seeds[0]) begin
          $error("seed mismatch: expected %h, actual %h", pending_seeds[0], out_if.seed);
          err_count++;
        end
        void'(pending_seeds.pop_front());
        seeds_checked++;
      end
    end
  end

  initial begin
    msg_word_t w;
    int nwords;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_word <= '0;
    in_if.wide_word <= 1'b0;
    in_if.last_word <= 1'b0;
    in_calm       = 1'b0;
    err_count     = 0;
    words_sent    = 0;
    msgs_sent     = 0;
    seeds_checked = 0;
    prefix_hash   = absorb_word(absorb_word(OffsetBasis, DomainWord, 1'b1), VersionWord,
                                1'b0);
    running_hash  = prefix_hash;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_word(directed_words[i]);
    end

    // Random messages, mostly short, now and then a long one.
    while (words_sent < NumDirected + NumRandomWords) begin
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      for (int k = 0; k < nwords; k++) begin
        w.data = random_data();
        w.wide = 1'($urandom_range(0, 1));
        w.last = (k == nwords - 1);
        send_word(w);
      end
    end
    in_if.valid <= 1'b0;

    while (pending_seeds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d words in %0d messages of narrow and wide words,", words_sent,
             msgs_sent);
    $display("with %0d seeds compared under random gaps on both sides.", seeds_checked);
    if (err_count == 0 && pending_seeds.size() == 0) begin
      $display("fnv1a_splitmix_seed_hash_top_tb: PASS");
    end else begin
      $display("fnv1a_splitmix_seed_hash_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d seeds still outstanding.", pending_seeds.size());
    $display("fnv1a_splitmix_seed_hash_top_tb: FAIL");
    $finish;
  end

endmodule
